// ===== rtl/sha1_message_digest_top_assert.svh =====
// Assertion macros shared by the checker
`ifndef SHA1_MESSAGE_DIGEST_TOP_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_TOP_ASSERT_SVH

// Condition that must hold at every clock edge out of reset
`define SHA1MD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequence that must hold in the cycle after the trigger
`define SHA1MD_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sha1md_pkg.sv =====
`default_nettype none
package sha1md_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned NumWords = 5;
  localparam int unsigned BlockW   = 512;
  localparam int unsigned LenW     = 64;
  localparam int unsigned Rounds   = 80;

  typedef logic [WordW-1:0] word_t;
  typedef logic [NumWords-1:0][WordW-1:0] words5_t;
  typedef logic [6:0] rnd_t;
  typedef logic [5:0] fill_t;
  typedef logic [2:0] widx_t;

  localparam words5_t InitWords = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [7:0] PadMarker = 8'h80;
  localparam fill_t      LenPos    = 6'd56;
  localparam fill_t      LastByte  = 6'd63;
  localparam rnd_t       LastRound = 7'(Rounds - 1);
  localparam widx_t      LastWidx  = 3'(NumWords - 1);

  localparam logic OpAbsorb = 1'b0;
  localparam logic OpFinish = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_PAD,
    ST_OUT
  } state_t;

  // Control from the sequencer to the compression unit
  typedef struct packed {
    logic       load_byte;
    logic [7:0] data;
    logic       start;
  } cmp_ctl_t;

  typedef struct packed {
    logic done;
  } cmp_sts_t;

  function automatic word_t rotl(input word_t x, input int unsigned n);
    return (x << n) | (x >> (WordW - n));
  endfunction

  function automatic word_t round_f(input rnd_t t, input word_t b, input word_t c,
                                    input word_t d);
    word_t f;
    case (t) inside
      [7'd0:7'd19]:  f = (b & c) | (~b & d);
      [7'd40:7'd59]: f = (b & c) | (b & d) | (c & d);
      default:       f = b ^ c ^ d;
    endcase
    return f;
  endfunction

  function automatic word_t round_k(input rnd_t t);
    word_t k;
    case (t) inside
      [7'd0:7'd19]:  k = 32'h5A827999;
      [7'd20:7'd39]: k = 32'h6ED9EBA1;
      [7'd40:7'd59]: k = 32'h8F1BBCDC;
      default:       k = 32'hCA62C1D6;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sha1md_if.sv =====
`default_nettype none
// Input channel: one absorb or finish transaction
interface sha1md_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

// Result channel: one digest word per transaction
interface sha1md_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/sha1md_compress.sv =====
`default_nettype none
// Message window and one shared SHA-1 round unit, one round per cycle
module sha1md_compress (
  input  wire                  clk,
  input  wire                  rst_n,
  input  sha1md_pkg::cmp_ctl_t ctl,
  input  sha1md_pkg::words5_t  chain,
  output sha1md_pkg::cmp_sts_t sts,
  output sha1md_pkg::words5_t  work
);
  import sha1md_pkg::*;

  logic [BlockW-1:0] msg_r, msg_nxt;
  words5_t           work_r, work_nxt;
  rnd_t              rnd_r, rnd_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;

  word_t w_t, w_new, tmp;

  // Schedule word for this round sits at the top of the window
  assign w_t   = msg_r[BlockW-1 -: WordW];
  assign w_new = rotl(msg_r[BlockW-1-13*WordW -: WordW] ^ msg_r[BlockW-1-8*WordW -: WordW] ^
                      msg_r[BlockW-1-2*WordW -: WordW] ^ w_t, 1);
  assign tmp   = rotl(work_r[0], 5) + round_f(rnd_r, work_r[1], work_r[2], work_r[3]) +
                 work_r[4] + round_k(rnd_r) + w_t;

  always_comb begin
    msg_nxt  = msg_r;
    work_nxt = work_r;
    rnd_nxt  = rnd_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    // Shift a message byte into the window
    if (ctl.load_byte) begin
      msg_nxt = {msg_r[BlockW-9:0], ctl.data};
    end
    if (ctl.start) begin
      work_nxt = chain;
      rnd_nxt  = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      // Advance one round and slide the schedule window
      msg_nxt  = {msg_r[BlockW-WordW-1:0], w_new};
      work_nxt = {work_r[3], work_r[2], rotl(work_r[1], 30), work_r[0], tmp};
      rnd_nxt  = rnd_r + 7'd1;
      if (rnd_r == LastRound) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    msg_r  <= msg_nxt;
    work_r <= work_nxt;
    rnd_r  <= rnd_nxt;
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  assign sts.done = done_r;
  assign work     = work_r;

endmodule
`default_nettype wire

// ===== rtl/sha1_message_digest_top.sv =====
// Absorb: one byte per cycle while idle; the 64th byte of a block starts compression,
// and no byte is taken until it ends. Finish: padding bytes go in one per cycle
// (up to 64, or up to 72 with an extra block), each padded block is compressed, then
// five result transactions follow. The block runs one message at a time; the 80-round
// loop of the shared round unit sets the rate. Reset is synchronous, active low, and
// returns chaining words to the initial hash with empty buffer and zero length.
`default_nettype none
module sha1_message_digest_top (
  input wire          clk,
  input wire          rst_n,
  sha1md_in_if.sink   in_ch,
  sha1md_out_if.source out_ch
);
  import sha1md_pkg::*;

  state_t           state_r, state_nxt;
  fill_t            fill_r, fill_nxt;
  logic [LenW-1:0]  bit_len_r, bit_len_nxt;
  logic [LenW-1:0]  total_r, total_nxt;
  words5_t          chain_r, chain_nxt;
  logic             pad_r, pad_nxt;
  logic             extra_r, extra_nxt;
  logic             marker_r, marker_nxt;
  widx_t            idx_r, idx_nxt;

  cmp_ctl_t ctl;
  cmp_sts_t sts;
  words5_t  work;

  logic       in_acc, out_acc;
  logic [7:0] pad_byte;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  sha1md_compress u_cmp (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .chain (chain_r),
    .sts   (sts),
    .work  (work)
  );

  // Pick the padding byte: marker, then zeros, then the big-endian length
  always_comb begin
    if (marker_r) begin
      pad_byte = PadMarker;
    end else if (fill_r >= LenPos && !extra_r) begin
      pad_byte = total_r[LenW-1 -: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // Next state and register updates
  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    bit_len_nxt = bit_len_r;
    total_nxt   = total_r;
    chain_nxt   = chain_r;
    pad_nxt     = pad_r;
    extra_nxt   = extra_r;
    marker_nxt  = marker_r;
    idx_nxt     = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.op == OpAbsorb) begin
            fill_nxt    = fill_r + 6'd1;
            bit_len_nxt = bit_len_r + 64'd8;
            if (fill_r == LastByte) begin
              state_nxt = ST_ROUND;
            end
          end else begin
            total_nxt  = bit_len_r;
            pad_nxt    = 1'b1;
            marker_nxt = 1'b1;
            state_nxt  = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        fill_nxt = fill_r + 6'd1;
        if (marker_r) begin
          marker_nxt = 1'b0;
          extra_nxt  = (fill_r >= LenPos);
        end else if (fill_r >= LenPos && !extra_r) begin
          total_nxt = {total_r[LenW-9:0], 8'h00};
        end
        if (fill_r == LastByte) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (sts.done) begin
          for (int i = 0; i < NumWords; i++) begin
            chain_nxt[i] = chain_r[i] + work[i];
          end
          if (!pad_r) begin
            state_nxt = ST_IDLE;
          end else if (extra_r) begin
            extra_nxt = 1'b0;
            state_nxt = ST_PAD;
          end else begin
            idx_nxt   = '0;
            state_nxt = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == LastWidx) begin
            // Drop the message state and start over
            chain_nxt   = InitWords;
            bit_len_nxt = '0;
            fill_nxt    = '0;
            pad_nxt     = 1'b0;
            idx_nxt     = '0;
            state_nxt   = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and compression unit control
  always_comb begin
    ctl           = '0;
    in_ch.ready   = (state_r == ST_IDLE);
    out_ch.valid  = (state_r == ST_OUT);
    case (state_r)
      ST_IDLE: begin
        ctl.load_byte = in_acc && (in_ch.op == OpAbsorb);
        ctl.data      = in_ch.data_byte;
        ctl.start     = in_acc && (in_ch.op == OpAbsorb) && (fill_r == LastByte);
      end
      ST_PAD: begin
        ctl.load_byte = 1'b1;
        ctl.data      = pad_byte;
        ctl.start     = (fill_r == LastByte);
      end
      default: ctl = '0;
    endcase
  end

  assign out_ch.digest_word = chain_r[idx_r];
  assign out_ch.word_index  = idx_r;
  assign out_ch.last_word   = (idx_r == LastWidx);

  always_ff @(posedge clk) begin
    total_r <= total_nxt;
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      fill_r    <= '0;
      bit_len_r <= '0;
      chain_r   <= InitWords;
      pad_r     <= 1'b0;
      extra_r   <= 1'b0;
      marker_r  <= 1'b0;
      idx_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      bit_len_r <= bit_len_nxt;
      chain_r   <= chain_nxt;
      pad_r     <= pad_nxt;
      extra_r   <= extra_nxt;
      marker_r  <= marker_nxt;
      idx_r     <= idx_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sha1md_checker.sv =====
`default_nettype none
`include "sha1_message_digest_top_assert.svh"
// Port-level checks on the digest engine
module sha1md_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        in_op,
  input wire        out_valid,
  input wire        out_ready,
  input wire [2:0]  out_word_index,
  input wire        out_last_word
);
  import sha1md_pkg::*;

  // The engine never takes input while a digest is being emitted
  `SHA1MD_ASSERT_ALWAYS(a_no_overlap, !(out_valid && in_ready), "input ready during output")

  // Last flag marks exactly the final digest word
  `SHA1MD_ASSERT_ALWAYS(a_last_flag, !out_valid || (out_last_word == (out_word_index == LastWidx)), "last_word mismatch")

  // A finish transaction closes the input side
  `SHA1MD_ASSERT_NEXT(a_finish_busy, in_valid && in_ready && (in_op == OpFinish), !in_ready && !out_valid, "not busy after finish")

  // After the last word the engine is idle and ready again
  `SHA1MD_ASSERT_NEXT(a_back_idle, out_valid && out_ready && out_last_word, in_ready && !out_valid, "not idle after digest")

endmodule

bind sha1_message_digest_top sha1md_checker u_sha1md_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_op          (in_ch.op),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_word_index (out_ch.word_index),
  .out_last_word  (out_ch.last_word)
);
`default_nettype wire
